### rtl/core/joint_angle_cosine_macros.svh
// ----------------------------------------------------------------------------
// Joint angle cosine assertion macros
// Clocked, reset-qualified property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef JOINT_ANGLE_COSINE_MACROS_SVH
`define JOINT_ANGLE_COSINE_MACROS_SVH

// same-cycle implication
`define JAC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/jac_pkg.sv
// ----------------------------------------------------------------------------
// Joint angle cosine package
// Widths, beat types and stage structs shared by the pipeline.
// ----------------------------------------------------------------------------
package jac_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int COS_BITS   = FRAC_BITS + 2;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DOT_W      = SQ_W + 2;
    localparam int RW         = DIFF_W;
    localparam int REM_W      = RW + 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] end1_x;
        logic signed [COORD_BITS-1:0] end1_y;
        logic signed [COORD_BITS-1:0] end1_z;
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic signed [COORD_BITS-1:0] end2_x;
        logic signed [COORD_BITS-1:0] end2_y;
        logic signed [COORD_BITS-1:0] end2_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [COS_BITS-1:0] cosine_q14;
        logic                       degenerate;
    } t_out_beat;

    typedef struct packed {
        logic            vld;
        logic [SQ_W-1:0] sa;
        logic [SQ_W-1:0] sb;
        logic [SQ_W-1:0] mag;
        logic            neg;
        logic            degen;
    } t_root_in;

    typedef struct packed {
        logic            vld;
        logic [RW-1:0]   la;
        logic [RW-1:0]   lb;
        logic [SQ_W-1:0] mag;
        logic            neg;
        logic            degen;
    } t_root_out;

    typedef struct packed {
        logic            vld;
        logic [SQ_W-1:0] den;
        logic [SQ_W-1:0] mag;
        logic            neg;
        logic            degen;
    } t_div_in;

    typedef struct packed {
        logic                 vld;
        logic [FRAC_BITS-1:0] q;
        logic                 neg;
        logic                 degen;
        logic                 sat;
    } t_div_out;

endpackage

### rtl/core/jac_if.sv
// ----------------------------------------------------------------------------
// Joint angle cosine channels
// Valid/ready interfaces for the point triple and the cosine result.
// ----------------------------------------------------------------------------
interface jac_in_if import jac_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jac_out_if import jac_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/jac_root_pipe.sv
// ----------------------------------------------------------------------------
// Joint angle cosine root pipeline
// Two-lane digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module jac_root_pipe import jac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_root_in  i_in,
    output t_root_out o_out
);

    logic [SQ_W-1:0]  r_rad [0:RW-1][0:1];
    logic [REM_W-1:0] r_rem [0:RW-1][0:1];
    logic [RW-1:0]    r_q   [0:RW-1][0:1];
    logic             r_vld [0:RW-1];
    logic [SQ_W-1:0]  r_mag [0:RW-1];
    logic             r_neg [0:RW-1];
    logic             r_dgn [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [SQ_W-1:0]  c_rad [0:1];
        logic [REM_W-1:0] c_rem [0:1];
        logic [RW-1:0]    c_q   [0:1];
        logic             c_vld;
        logic [SQ_W-1:0]  c_mag;
        logic             c_neg;
        logic             c_dgn;

        if (k == 0) begin : g_head
            always_comb begin
                c_rad[0] = i_in.sa;
                c_rad[1] = i_in.sb;
                c_rem[0] = '0;
                c_rem[1] = '0;
                c_q[0]   = '0;
                c_q[1]   = '0;
                c_vld    = i_in.vld;
                c_mag    = i_in.mag;
                c_neg    = i_in.neg;
                c_dgn    = i_in.degen;
            end
        end else begin : g_body
            always_comb begin
                c_rad = r_rad[k-1];
                c_rem = r_rem[k-1];
                c_q   = r_q[k-1];
                c_vld = r_vld[k-1];
                c_mag = r_mag[k-1];
                c_neg = r_neg[k-1];
                c_dgn = r_dgn[k-1];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [REM_W-1:0] n_sh;
            logic [REM_W-1:0] n_trial;
            always_comb begin
                // bring down the next two radicand bits
                n_sh    = {c_rem[l][REM_W-3:0], c_rad[l][SQ_W-1-2*k -: 2]};
                n_trial = REM_W'({c_q[l], 2'b01});
            end
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rad[k][l] <= c_rad[l];
                    if (n_sh >= n_trial) begin
                        r_rem[k][l] <= n_sh - n_trial;
                        r_q[k][l]   <= {c_q[l][RW-2:0], 1'b1};
                    end else begin
                        r_rem[k][l] <= n_sh;
                        r_q[k][l]   <= {c_q[l][RW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_mag[k] <= c_mag;
                r_neg[k] <= c_neg;
                r_dgn[k] <= c_dgn;
            end
        end
    end

    always_comb begin
        o_out.vld   = r_vld[RW-1];
        o_out.la    = r_q[RW-1][0];
        o_out.lb    = r_q[RW-1][1];
        o_out.mag   = r_mag[RW-1];
        o_out.neg   = r_neg[RW-1];
        o_out.degen = r_dgn[RW-1];
    end

endmodule

### rtl/core/jac_div_pipe.sv
// ----------------------------------------------------------------------------
// Joint angle cosine divider pipeline
// Restoring fraction division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module jac_div_pipe import jac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_div_in  i_in,
    output t_div_out o_out
);

    logic [SQ_W-1:0]      r_rem [0:FRAC_BITS-1];
    logic [SQ_W-1:0]      r_den [0:FRAC_BITS-1];
    logic [FRAC_BITS-1:0] r_q   [0:FRAC_BITS-1];
    logic                 r_vld [0:FRAC_BITS-1];
    logic                 r_neg [0:FRAC_BITS-1];
    logic                 r_dgn [0:FRAC_BITS-1];
    logic                 r_sat [0:FRAC_BITS-1];

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
        logic [SQ_W-1:0]      c_rem;
        logic [SQ_W-1:0]      c_den;
        logic [FRAC_BITS-1:0] c_q;
        logic                 c_vld;
        logic                 c_neg;
        logic                 c_dgn;
        logic                 c_sat;
        logic [SQ_W:0]        n_sh;
        logic [SQ_W:0]        n_diff;

        if (k == 0) begin : g_head
            always_comb begin
                c_rem = i_in.mag;
                c_den = i_in.den;
                c_q   = '0;
                c_vld = i_in.vld;
                c_neg = i_in.neg;
                c_dgn = i_in.degen;
                c_sat = (i_in.mag >= i_in.den);
            end
        end else begin : g_body
            always_comb begin
                c_rem = r_rem[k-1];
                c_den = r_den[k-1];
                c_q   = r_q[k-1];
                c_vld = r_vld[k-1];
                c_neg = r_neg[k-1];
                c_dgn = r_dgn[k-1];
                c_sat = r_sat[k-1];
            end
        end

        always_comb begin
            n_sh   = {c_rem, 1'b0};
            n_diff = n_sh - {1'b0, c_den};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_den[k] <= c_den;
                r_neg[k] <= c_neg;
                r_dgn[k] <= c_dgn;
                r_sat[k] <= c_sat;
                if (n_sh >= {1'b0, c_den}) begin
                    r_rem[k] <= n_diff[SQ_W-1:0];
                    r_q[k]   <= {c_q[FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k] <= n_sh[SQ_W-1:0];
                    r_q[k]   <= {c_q[FRAC_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_out.vld   = r_vld[FRAC_BITS-1];
        o_out.q     = r_q[FRAC_BITS-1];
        o_out.neg   = r_neg[FRAC_BITS-1];
        o_out.degen = r_dgn[FRAC_BITS-1];
        o_out.sat   = r_sat[FRAC_BITS-1];
    end

endmodule

### rtl/core/joint_angle_cosine.sv
// ----------------------------------------------------------------------------
// Joint angle cosine
// Cosine of the angle at a vertex between two arms of a 3D point triple.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt carries one point triple per beat (end1, vertex, end2, signed mm).
//   o_cos returns one beat per triple: cosine_q14 (Q14, +-16384) and a
//   degenerate flag that is set, with cosine 0, when an arm has zero length.
//   The stages run in order: the arm differences, products and sums, the
//   square roots (one root bit per stage), the length product, the
//   division (one quotient bit per stage) and the output register.
//   Throughput is one triple per cycle while the receiver does not stall;
//   every stage is a full pipeline stage.
//   Reset clears all stage valid bits; no results are pending afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and i_pt.ready drops; it rises again as soon as that result is taken.
// ----------------------------------------------------------------------------
`include "joint_angle_cosine_macros.svh"

module joint_angle_cosine import jac_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jac_in_if.sink       i_pt,
    jac_out_if.source    o_cos
);

    logic                     w_adv;
    logic                     r_s1_vld;
    logic signed [DIFF_W-1:0] r_a [0:2];
    logic signed [DIFF_W-1:0] r_b [0:2];
    logic                     r_s2_vld;
    logic signed [SQ_W-1:0]   r_pd [0:2];
    logic signed [SQ_W-1:0]   r_pa [0:2];
    logic signed [SQ_W-1:0]   r_pb [0:2];
    t_root_in                 r_s3;
    t_root_in                 n_s3;
    logic signed [DOT_W-1:0]  n_dot;
    t_root_out                w_root;
    t_div_in                  r_s4;
    t_div_out                 w_div;
    logic                     r_out_vld;
    t_out_beat                r_out;
    logic [FRAC_BITS:0]       n_qf;
    logic [COS_BITS-1:0]      n_qx;

    // advance whenever the output slot is free or being emptied
    assign w_adv      = !r_out_vld || o_cos.ready;
    assign i_pt.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_pt.valid;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= w_div.vld;
        end
    end

    // arm vectors
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a[0] <= DIFF_W'(i_pt.data.end1_x) - DIFF_W'(i_pt.data.vertex_x);
            r_a[1] <= DIFF_W'(i_pt.data.end1_y) - DIFF_W'(i_pt.data.vertex_y);
            r_a[2] <= DIFF_W'(i_pt.data.end1_z) - DIFF_W'(i_pt.data.vertex_z);
            r_b[0] <= DIFF_W'(i_pt.data.end2_x) - DIFF_W'(i_pt.data.vertex_x);
            r_b[1] <= DIFF_W'(i_pt.data.end2_y) - DIFF_W'(i_pt.data.vertex_y);
            r_b[2] <= DIFF_W'(i_pt.data.end2_z) - DIFF_W'(i_pt.data.vertex_z);
        end
    end

    // products
    for (genvar i = 0; i < 3; i++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pd[i] <= r_a[i] * r_b[i];
                r_pa[i] <= r_a[i] * r_a[i];
                r_pb[i] <= r_b[i] * r_b[i];
            end
        end
    end

    // sums, zero-length test and dot magnitude
    always_comb begin
        n_dot    = DOT_W'(r_pd[0]) + DOT_W'(r_pd[1]) + DOT_W'(r_pd[2]);
        n_s3.vld = r_s2_vld;
        n_s3.sa  = SQ_W'(unsigned'(r_pa[0])) + SQ_W'(unsigned'(r_pa[1]))
                 + SQ_W'(unsigned'(r_pa[2]));
        n_s3.sb  = SQ_W'(unsigned'(r_pb[0])) + SQ_W'(unsigned'(r_pb[1]))
                 + SQ_W'(unsigned'(r_pb[2]));
        n_s3.neg = n_dot[DOT_W-1];
        n_s3.mag = n_dot[DOT_W-1] ? SQ_W'(-n_dot) : SQ_W'(n_dot);
        n_s3.degen = (n_s3.sa == '0) || (n_s3.sb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (w_adv) begin
            r_s3.vld <= n_s3.vld;
        end
        if (w_adv) begin
            r_s3.sa    <= n_s3.sa;
            r_s3.sb    <= n_s3.sb;
            r_s3.mag   <= n_s3.mag;
            r_s3.neg   <= n_s3.neg;
            r_s3.degen <= n_s3.degen;
        end
    end

    jac_root_pipe u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_in    (r_s3),
        .o_out   (w_root)
    );

    // length product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else if (w_adv) begin
            r_s4.vld <= w_root.vld;
        end
        if (w_adv) begin
            r_s4.den   <= SQ_W'(w_root.la * w_root.lb);
            r_s4.mag   <= w_root.mag;
            r_s4.neg   <= w_root.neg;
            r_s4.degen <= w_root.degen;
        end
    end

    jac_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_in    (r_s4),
        .o_out   (w_div)
    );

    // saturate, apply sign, force degenerate to zero
    always_comb begin
        n_qf = w_div.sat ? (FRAC_BITS+1)'(1) << FRAC_BITS : {1'b0, w_div.q};
        n_qx = w_div.neg ? -COS_BITS'(n_qf) : COS_BITS'(n_qf);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.degenerate <= w_div.degen;
            r_out.cosine_q14 <= w_div.degen ? '0 : signed'(n_qx);
        end
    end

    assign o_cos.valid = r_out_vld;
    assign o_cos.data  = r_out;

    `JAC_ASSERT_IMPL(a_degen_zero, o_cos.valid && o_cos.data.degenerate, o_cos.data.cosine_q14 == '0, "degenerate result with nonzero cosine")
    `JAC_ASSERT_IMPL(a_cos_range, o_cos.valid, (o_cos.data.cosine_q14 <= COS_BITS'(16384)) && (o_cos.data.cosine_q14 >= -COS_BITS'(16384)), "cosine outside unit range")
    `JAC_ASSERT_NEXT(a_enter, i_pt.valid && i_pt.ready, r_s1_vld, "accepted beat did not enter the pipeline")
    `JAC_ASSERT_NEXT(a_hold, r_out_vld && !o_cos.ready, r_out_vld && $stable(r_s4.den), "pipeline moved during stall")

endmodule

### tb/sv/jac_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joint angle cosine testbench package
// Golden cosine prediction for one point triple, used by the testbench top.
// ----------------------------------------------------------------------------
package jac_tb_pkg;
    import jac_pkg::*;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_out_beat predict_cosine(t_in_beat p);
        longint ax, ay, az, bx, by, bz, dot, sa, sb;
        longint unsigned mag, den, q, r;
        t_out_beat res;
        ax = longint'(p.end1_x) - longint'(p.vertex_x);
        ay = longint'(p.end1_y) - longint'(p.vertex_y);
        az = longint'(p.end1_z) - longint'(p.vertex_z);
        bx = longint'(p.end2_x) - longint'(p.vertex_x);
        by = longint'(p.end2_y) - longint'(p.vertex_y);
        bz = longint'(p.end2_z) - longint'(p.vertex_z);
        dot = ax * bx + ay * by + az * bz;
        sa = ax * ax + ay * ay + az * az;
        sb = bx * bx + by * by + bz * bz;
        res = '0;
        if (sa == 0 || sb == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        den = int_sqrt(sa) * int_sqrt(sb);
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        if (mag >= den) begin
            q = 64'd1 << FRAC_BITS;
        end else begin
            q = 0;
            r = mag;
            for (int i = 0; i < FRAC_BITS; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 64'd1;
                end
            end
        end
        if (dot < 0) q = -q;
        res.cosine_q14 = q[COS_BITS-1:0];
        return res;
    endfunction
endpackage

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joint angle cosine testbench
// Feeds point triples through the pipeline under random idling and a long
// output stall, and checks each cosine beat against a golden prediction.
// ----------------------------------------------------------------------------
module tb;
    import jac_pkg::*;
    import jac_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;

    jac_in_if  pt_if ();
    jac_out_if cos_if ();

    joint_angle_cosine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .o_cos   (cos_if.source)
    );

    t_in_beat  triple_q[$];
    t_out_beat cosine_q[$];
    int        n_errors;
    bit        stim_done;
    int        send_gap;
    int        recv_gap;
    int        hold_cnt;
    bit        hold_armed;
    int        beats_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 31)) - 16'd16;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_beat rand_triple();
        t_in_beat p;
        p.vertex_x = rand_coord();
        p.vertex_y = rand_coord();
        p.vertex_z = rand_coord();
        p.end1_x = rand_coord();
        p.end1_y = rand_coord();
        p.end1_z = rand_coord();
        p.end2_x = rand_coord();
        p.end2_y = rand_coord();
        p.end2_z = rand_coord();
        case ($urandom_range(0, 15))
            0: begin
                p.end1_x = p.vertex_x; p.end1_y = p.vertex_y; p.end1_z = p.vertex_z;
            end
            1: begin
                p.end2_x = p.vertex_x; p.end2_y = p.vertex_y; p.end2_z = p.vertex_z;
            end
            2: begin
                // collinear arms in the same direction: cosine at +1, exercises saturation
                p.end2_x = p.end1_x; p.end2_y = p.end1_y; p.end2_z = p.end1_z;
            end
            3: begin
                p.end2_x = 16'(2 * p.vertex_x - p.end1_x);
                p.end2_y = 16'(2 * p.vertex_y - p.end1_y);
                p.end2_z = 16'(2 * p.vertex_z - p.end1_z);
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_in_beat mk(int x1, int y1, int z1, int vx, int vy, int vz,
                                    int x2, int y2, int z2);
        t_in_beat p;
        p.end1_x = 16'(x1); p.end1_y = 16'(y1); p.end1_z = 16'(z1);
        p.vertex_x = 16'(vx); p.vertex_y = 16'(vy); p.vertex_z = 16'(vz);
        p.end2_x = 16'(x2); p.end2_y = 16'(y2); p.end2_z = 16'(z2);
        return p;
    endfunction

    initial begin
        triple_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        triple_q.push_back(mk(5, 0, 0, 0, 0, 0, 0, 0, 0));
        triple_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 7, 0));
        triple_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
        triple_q.push_back(mk(1, 1, 0, 0, 0, 0, 1, 1, 0));
        triple_q.push_back(mk(1, 1, 1, 0, 0, 0, -1, -1, -1));
        triple_q.push_back(mk(3, 4, 0, 0, 0, 0, 4, 3, 0));
        triple_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                              32767, 32767, 32767));
        triple_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                              -32768, -32768, -32768));
        triple_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                              -32768, 32767, 32767));
        triple_q.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768,
                              -32768, -32768, 32767));
        triple_q.push_back(mk(2, 1, 0, 0, 0, 0, 1, 2, 0));
        triple_q.push_back(mk(-1, 0, 0, 0, 0, 0, 1, 1, 1));
        triple_q.push_back(mk(100, 1, 0, 0, 0, 0, -100, 1, 0));
        triple_q.push_back(mk(32767, 0, 0, 0, 0, 0, 0, -32768, 0));
        triple_q.push_back(mk(-1, -1, -1, -1, -1, -1, 5, 5, 5));
        for (int i = 0; i < 1430; i++) triple_q.push_back(rand_triple());
        stim_done = 1'b1;
    end

    // sender: hold the beat until accepted, then draw a gap for the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
            pt_if.data  <= '0;
            send_gap    <= 0;
        end else if (pt_if.valid && !pt_if.ready) begin
            // hold
        end else if (send_gap > 0) begin
            pt_if.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end else if (triple_q.size() > 0) begin
            t_in_beat p;
            p = triple_q.pop_front();
            cosine_q.push_back(predict_cosine(p));
            pt_if.valid <= 1'b1;
            pt_if.data  <= p;
            send_gap    <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 8);
        end else begin
            pt_if.valid <= 1'b0;
        end
    end

    // receiver: random idling plus one long hold-off to fill the pipeline
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cos_if.ready <= 1'b0;
            recv_gap     <= 0;
            hold_cnt     <= 0;
            hold_armed   <= 1'b1;
            beats_out    <= 0;
        end else begin
            if (cos_if.valid && cos_if.ready) begin
                beats_out <= beats_out + 1;
                if (cosine_q.size() == 0) begin
                    $error("unexpected cosine beat %0d", cos_if.data.cosine_q14);
                    n_errors++;
                end else begin
                    t_out_beat e;
                    e = cosine_q.pop_front();
                    if (cos_if.data.cosine_q14 !== e.cosine_q14) begin
                        $error("cosine_q14 expected %0d actual %0d",
                               e.cosine_q14, cos_if.data.cosine_q14);
                        n_errors++;
                    end
                    if (cos_if.data.degenerate !== e.degenerate) begin
                        $error("degenerate expected %0d actual %0d",
                               e.degenerate, cos_if.data.degenerate);
                        n_errors++;
                    end
                end
            end
            if (hold_armed && beats_out == 300) begin
                hold_armed   <= 1'b0;
                hold_cnt     <= 200;
                cos_if.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt     <= hold_cnt - 1;
                cos_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap     <= recv_gap - 1;
                cos_if.ready <= 1'b0;
            end else begin
                cos_if.ready <= 1'b1;
                if (cos_if.valid && cos_if.ready)
                    recv_gap <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && triple_q.size() == 0);
        @(posedge i_clk);
        while (pt_if.valid || cosine_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && cosine_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
